### rtl/dmc_pkg.sv
// shared types, register map and constants for the direct-mapped cache timing model
// no dependencies; used by dmc_addr_split and direct_mapped_cache_timing_model

package dmc_pkg;

  // sizing
  localparam int MAX_SETS_DEFAULT = 256;
  localparam int TAG_W            = 30;
  localparam int PEN_W            = 18;
  localparam int CNT_W            = 32;
  localparam int ADDR_W           = 32;
  localparam int IDX_W            = 15;   // widest set index before reduction
  localparam int APB_AW           = 5;
  localparam int APB_DW           = 32;

  // write policy codes (code 3 behaves as write-back)
  localparam logic [1:0] POL_WT_NOALLOC = 2'd0;
  localparam logic [1:0] POL_WT_ALLOC   = 2'd1;
  localparam logic [1:0] POL_WRITE_BACK = 2'd2;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_WRITE_POLICY = 3'd0;
  localparam logic [2:0] REG_SET_BITS     = 3'd1;
  localparam logic [2:0] REG_BLOCK_BITS   = 3'd2;
  localparam logic [2:0] REG_MISS_SETUP   = 3'd3;
  localparam logic [2:0] REG_MISS_BURST   = 3'd4;

  // register reset values
  localparam logic [1:0]  RST_WRITE_POLICY = POL_WRITE_BACK;
  localparam logic [3:0]  RST_SET_BITS     = 4'd8;
  localparam logic [2:0]  RST_BLOCK_BITS   = 3'd2;
  localparam logic [15:0] RST_MISS_SETUP   = 16'd10;
  localparam logic [15:0] RST_MISS_BURST   = 16'd16;

  // request kinds
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [TAG_W-1:0] tag;
  } line_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPLIT,
    ST_REDUCE,
    ST_READ,
    ST_UPDATE
  } state_t;

  // index width for a store of n sets, at least one bit
  function automatic int set_width(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

### rtl/dmc_addr_split.sv
// splits a byte address into tag and set index, reducing the index modulo the set count
// depends on dmc_pkg; three register stages, reduction by reciprocal multiply

module dmc_addr_split #(
  parameter int MAX_SETS = dmc_pkg::MAX_SETS_DEFAULT
) (
  input  logic                                        clk,
  input  logic                                        load,
  input  logic [dmc_pkg::ADDR_W-1:0]                  byte_address,
  input  logic [3:0]                                  set_index_bits,
  input  logic [2:0]                                  block_word_bits,
  output logic [dmc_pkg::set_width(MAX_SETS)-1:0]     set_index,
  output logic [dmc_pkg::TAG_W-1:0]                   tag
);

  localparam int SET_W = dmc_pkg::set_width(MAX_SETS);
  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / MAX_SETS);

  logic [dmc_pkg::TAG_W-1:0] word;
  logic [dmc_pkg::TAG_W-1:0] blk;
  logic [dmc_pkg::IDX_W-1:0] idx_mask;
  logic [4:0]                tag_lsb;
  logic [dmc_pkg::IDX_W-1:0] idx;
  logic [dmc_pkg::IDX_W-1:0] quot;
  logic [47:0]               prod;
  logic [31:0]               quot_mul;
  logic [31:0]               rem_raw;
  logic [31:0]               rem;

  // stage one: shifts and mask
  always_comb begin
    word     = byte_address[dmc_pkg::ADDR_W-1:2];
    blk      = word >> block_word_bits;
    idx_mask = ~({dmc_pkg::IDX_W{1'b1}} << set_index_bits);
    tag_lsb  = {2'b00, block_word_bits} + {1'b0, set_index_bits};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      idx <= blk[dmc_pkg::IDX_W-1:0] & idx_mask;
      tag <= word >> tag_lsb;
    end
  end

  // stage two: quotient estimate, low by at most one
  assign prod = 48'(idx) * 48'(RECIP);

  always_ff @(posedge clk) begin
    quot <= prod[46:32];
  end

  // stage three: remainder with one correction step
  always_comb begin
    quot_mul = 32'(quot) * 32'(MAX_SETS);
    rem_raw  = 32'(idx) - quot_mul;
    rem      = (rem_raw >= 32'(MAX_SETS)) ? rem_raw - 32'(MAX_SETS) : rem_raw;
  end

  always_ff @(posedge clk) begin
    set_index <= rem[SET_W-1:0];
  end

endmodule

### rtl/direct_mapped_cache_timing_model.sv
// top level of the direct-mapped cache timing model: config registers, tag store, sequencer
// depends on dmc_pkg and dmc_addr_split

// Models the tag store and miss timing of a direct-mapped cache. Each request transfer is one
// read or write to a byte address; each response transfer gives hit/miss, the stall penalty
// charged to that access and the running hit, miss, read and write counts (all wrap). After
// reset the tag store is swept clear, one set a cycle, over MAX_SETS sets (256 by default);
// req_stall stays high during the sweep but the register port works throughout. The request
// transfer registers the split address; the sequencer then steps through the modulo reduction
// of the set index (two constant multiplies, quotient then remainder registered), the
// registered tag store read and the update, which writes the line and loads the response
// register. One access is in flight at a time, so a new request is taken only once the
// access in flight has loaded its response; a waiting response does not block the next
// request, but that access then holds in its update state until the response register
// drains. Policy and geometry registers must only be written while idle.

module direct_mapped_cache_timing_model #(
  parameter int MAX_SETS = dmc_pkg::MAX_SETS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  // request channel
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic                           req_type,
  input  logic [dmc_pkg::ADDR_W-1:0]     byte_address,
  // response channel
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic                           was_hit,
  output logic [dmc_pkg::PEN_W-1:0]      penalty_cycles,
  output logic [dmc_pkg::CNT_W-1:0]      hit_count,
  output logic [dmc_pkg::CNT_W-1:0]      miss_count,
  output logic [dmc_pkg::CNT_W-1:0]      read_count,
  output logic [dmc_pkg::CNT_W-1:0]      write_count,
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dmc_pkg::APB_AW-1:0]     paddr,
  input  logic [dmc_pkg::APB_DW-1:0]     pwdata,
  output logic [dmc_pkg::APB_DW-1:0]     prdata,
  output logic                           pready
);

  localparam int SET_W = dmc_pkg::set_width(MAX_SETS);
  localparam logic [SET_W-1:0] LAST_SET = SET_W'(MAX_SETS - 1);

  // configuration registers
  logic [1:0]  write_policy;
  logic [3:0]  set_index_bits;
  logic [2:0]  block_word_bits;
  logic [15:0] miss_setup_cycles;
  logic [15:0] miss_burst_cycles;

  logic       reg_wr;
  logic [2:0] reg_idx;

  // sequencer
  dmc_pkg::state_t state;
  dmc_pkg::state_t state_next;
  logic [SET_W-1:0] clr_idx;
  logic             clr_last;
  logic             req_accept;
  logic             slot_free;
  logic             out_load;

  // request held for the access in flight
  logic req_write;

  // address split outputs
  logic [SET_W-1:0]          set_index;
  logic [dmc_pkg::TAG_W-1:0] tag;

  // tag store
  dmc_pkg::line_t   mem [MAX_SETS];
  dmc_pkg::line_t   rd_line;
  logic             mem_rd_en;
  logic             mem_wr_en;
  logic [SET_W-1:0] mem_wr_addr;
  dmc_pkg::line_t   mem_wr_data;

  // update datapath
  logic                      hit;
  logic                      write_back;
  logic [16:0]               full_cost;
  logic [16:0]               word_cost;
  logic [dmc_pkg::PEN_W-1:0] penalty;
  logic                      hit_flag;
  logic                      inc_hit;
  logic                      inc_miss;
  logic                      line_wr;
  dmc_pkg::line_t            new_line;

  // ---------------------------------------------------------------------------------------
  // register port: writes land on the access phase, reads are combinational
  // ---------------------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign reg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_policy      <= dmc_pkg::RST_WRITE_POLICY;
      set_index_bits    <= dmc_pkg::RST_SET_BITS;
      block_word_bits   <= dmc_pkg::RST_BLOCK_BITS;
      miss_setup_cycles <= dmc_pkg::RST_MISS_SETUP;
      miss_burst_cycles <= dmc_pkg::RST_MISS_BURST;
    end else if (reg_wr) begin
      unique case (reg_idx)
        dmc_pkg::REG_WRITE_POLICY: write_policy      <= pwdata[1:0];
        dmc_pkg::REG_SET_BITS:     set_index_bits    <= pwdata[3:0];
        dmc_pkg::REG_BLOCK_BITS:   block_word_bits   <= pwdata[2:0];
        dmc_pkg::REG_MISS_SETUP:   miss_setup_cycles <= pwdata[15:0];
        dmc_pkg::REG_MISS_BURST:   miss_burst_cycles <= pwdata[15:0];
        default: ;   // unmapped index, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      dmc_pkg::REG_WRITE_POLICY: prdata = 32'(write_policy);
      dmc_pkg::REG_SET_BITS:     prdata = 32'(set_index_bits);
      dmc_pkg::REG_BLOCK_BITS:   prdata = 32'(block_word_bits);
      dmc_pkg::REG_MISS_SETUP:   prdata = 32'(miss_setup_cycles);
      dmc_pkg::REG_MISS_BURST:   prdata = 32'(miss_burst_cycles);
      default:                   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // address split and set reduction
  // ---------------------------------------------------------------------------------------
  dmc_addr_split #(
    .MAX_SETS (MAX_SETS)
  ) u_addr_split (
    .clk             (clk),
    .load            (req_accept),
    .byte_address    (byte_address),
    .set_index_bits  (set_index_bits),
    .block_word_bits (block_word_bits),
    .set_index       (set_index),
    .tag             (tag)
  );

  always_ff @(posedge clk) begin
    if (req_accept) begin
      req_write <= req_type;
    end
  end

  // ---------------------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------------------
  assign clr_last  = (clr_idx == LAST_SET);
  // the response register is free when empty or being drained this cycle
  assign slot_free = ~rsp_valid | ~rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= dmc_pkg::ST_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == dmc_pkg::ST_CLEAR) begin
        clr_idx <= clr_idx + SET_W'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      dmc_pkg::ST_CLEAR:  if (clr_last)  state_next = dmc_pkg::ST_IDLE;
      dmc_pkg::ST_IDLE:   if (req_valid) state_next = dmc_pkg::ST_SPLIT;
      dmc_pkg::ST_SPLIT:  state_next = dmc_pkg::ST_REDUCE;
      dmc_pkg::ST_REDUCE: state_next = dmc_pkg::ST_READ;
      dmc_pkg::ST_READ:   state_next = dmc_pkg::ST_UPDATE;
      dmc_pkg::ST_UPDATE: if (slot_free) state_next = dmc_pkg::ST_IDLE;
      default:            state_next = dmc_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    req_stall   = 1'b1;
    mem_rd_en   = 1'b0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = set_index;
    mem_wr_data = new_line;
    out_load    = 1'b0;
    unique case (state)
      dmc_pkg::ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_idx;
        mem_wr_data = '0;
      end
      dmc_pkg::ST_IDLE: begin
        req_stall = 1'b0;
      end
      dmc_pkg::ST_READ: begin
        mem_rd_en = 1'b1;
      end
      dmc_pkg::ST_UPDATE: begin
        out_load  = slot_free;
        mem_wr_en = slot_free & line_wr;
      end
      default: ;
    endcase
  end

  assign req_accept = req_valid & ~req_stall;

  // ---------------------------------------------------------------------------------------
  // tag store: one write port, one registered read port
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      mem[mem_wr_addr] <= mem_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_rd_en) begin
      rd_line <= mem[set_index];
    end
  end

  // ---------------------------------------------------------------------------------------
  // line update and penalty
  // ---------------------------------------------------------------------------------------
  always_comb begin
    hit        = rd_line.valid & (rd_line.tag == tag);
    write_back = (write_policy >= dmc_pkg::POL_WRITE_BACK);
    full_cost  = 17'(miss_setup_cycles) + 17'(miss_burst_cycles);
    word_cost  = 17'(miss_setup_cycles) + 17'(miss_burst_cycles >> block_word_bits);

    penalty  = '0;
    hit_flag = 1'b0;
    inc_hit  = 1'b0;
    inc_miss = 1'b0;
    line_wr  = 1'b0;
    new_line = rd_line;

    priority if (req_write == dmc_pkg::REQ_READ) begin
      if (hit) begin
        inc_hit  = 1'b1;
        hit_flag = 1'b1;
      end else begin
        inc_miss = 1'b1;
        // a dirty victim costs a second full block transfer under write-back
        if (write_back && rd_line.dirty) begin
          penalty = 18'(full_cost) + 18'(full_cost);
        end else begin
          penalty = 18'(full_cost);
        end
        if (write_back) begin
          new_line.dirty = 1'b0;
        end
        new_line.valid = 1'b1;
        new_line.tag   = tag;
        line_wr        = 1'b1;
      end
    end else if (write_policy == dmc_pkg::POL_WT_NOALLOC) begin
      // lookup result ignored and line left as it is, no hit or miss counted
      penalty = 18'(word_cost);
    end else if (hit) begin
      inc_hit  = 1'b1;
      hit_flag = 1'b1;
      if (write_back) begin
        new_line.dirty = 1'b1;
        line_wr        = 1'b1;
      end else begin
        penalty = 18'(word_cost);
      end
    end else begin
      inc_miss = 1'b1;
      penalty  = 18'(word_cost) + 18'(full_cost);
      if (write_back) begin
        new_line.dirty = 1'b0;
      end
      new_line.valid = 1'b1;
      new_line.tag   = tag;
      line_wr        = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------------------
  // response register and running counts; counts only move on a load, so they double as
  // the response payload and hold while the response is stalled
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid   <= 1'b0;
      hit_count   <= '0;
      miss_count  <= '0;
      read_count  <= '0;
      write_count <= '0;
    end else begin
      if (out_load) begin
        rsp_valid <= 1'b1;
        if (inc_hit) begin
          hit_count <= hit_count + 32'd1;
        end
        if (inc_miss) begin
          miss_count <= miss_count + 32'd1;
        end
        if (req_write == dmc_pkg::REQ_WRITE) begin
          write_count <= write_count + 32'd1;
        end else begin
          read_count <= read_count + 32'd1;
        end
      end else if (~rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      was_hit        <= hit_flag;
      penalty_cycles <= penalty;
    end
  end

endmodule
